### design/uvs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and default sizes for the unique value set store.
// No dependencies.
package uvs_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_IN_W     = 32;
  localparam int COUNT_W        = 7;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_DUP    = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]            action;
    logic [VALUE_IN_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE,
    S_SH_READ,
    S_SH_WRITE,
    S_OUTPUT
  } state_t;

endpackage

### design/unique_value_set_store.sv
`timescale 1ns / 1ps
// Unique value set store: packed entry memory, scan/shift sequencer, result register.
// Depends on uvs_pkg.
//
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   uvs_pkg::in_item_t  (action, value)
// out_     output     out_valid / out_ready uvs_pkg::out_item_t (found, status, count)
//
// One item at a time; the single memory read port sets the pace. Each item scans the
// entries from position 0 until a hit or the fill level (no scan on an empty store); a
// removal then shifts the later entries down one place. Synchronous active-low reset
// empties the store at once. A stalled result waits in the output register while the
// next item is taken; the sequencer holds in S_OUTPUT only if that register is busy.
module unique_value_set_store #(
  parameter int CAPACITY   = uvs_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = uvs_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  uvs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output uvs_pkg::out_item_t out_data
);
  import uvs_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [IW-1:0]         ra;
  logic                  we;
  logic [IW-1:0]         wa;
  logic [VALUE_BITS-1:0] wd;

  state_t                state_r, state_nxt;
  logic [1:0]            act_r, act_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic                  found_r, found_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic [CW-1:0]         idx_inc;

  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ra            = idx_r;
    we            = 1'b0;
    wa            = idx_r;
    wd            = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_data.action;
          val_nxt   = VALUE_BITS'(in_data.value);
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (fill_r == '0) ? S_DECIDE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_data_r == val_r) begin
          found_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else if (idx_inc >= fill_r) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_inc[IW-1:0];
          state_nxt = S_READ;
        end
      end
      S_DECIDE: begin
        state_nxt = S_OUTPUT;
        case (act_r)
          ACT_INSERT: begin
            if (found_r) begin
              status_nxt = STAT_DUP;
            end else if (fill_r >= CAP_C) begin
              status_nxt = STAT_FULL;
            end else begin
              we         = 1'b1;
              wa         = fill_r[IW-1:0];
              wd         = val_r;
              fill_nxt   = fill_r + CW'(1);
              status_nxt = STAT_DONE;
            end
          end
          ACT_REMOVE: begin
            if (found_r) begin
              status_nxt = STAT_DONE;
              state_nxt  = S_SH_READ;
            end else begin
              status_nxt = STAT_ABSENT;
            end
          end
          default: begin
            status_nxt = found_r ? STAT_DONE : STAT_ABSENT;
          end
        endcase
      end
      S_SH_READ: begin
        ra = idx_inc[IW-1:0];
        if (idx_inc >= fill_r) begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_OUTPUT;
        end else begin
          state_nxt = S_SH_WRITE;
        end
      end
      S_SH_WRITE: begin
        we        = 1'b1;
        wa        = idx_r;
        wd        = rd_data_r;
        idx_nxt   = idx_inc[IW-1:0];
        state_nxt = S_SH_READ;
      end
      S_OUTPUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.found  = found_r;
          out_data_nxt.status = status_r;
          out_data_nxt.count  = COUNT_W'(fill_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_C)
    else $error("fill above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted item not processed");

  a_append_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    we && state_r == S_DECIDE |-> fill_r < CAP_C && !found_r)
    else $error("append into full store or duplicate");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SH_WRITE |-> idx_inc < fill_r && act_r == ACT_REMOVE)
    else $error("shift beyond fill");
`endif

endmodule

### dv/unique_value_set_store_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for unique_value_set_store: directed and random insert,
// remove and query items checked against a set model kept in a small scoreboard.
// Depends on uvs_pkg and the unique_value_set_store RTL.
module unique_value_set_store_tb;
  import uvs_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int POOL_SIZE    = 80;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 4 * CAPACITY + 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam logic [63:0] WIDE_MASK  =
    (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

  class uvs_scoreboard;
    logic [VALUE_IN_W-1:0] members[$];
    out_item_t             expected_q[$];
    int                    errors;
    int                    results_checked;
    int                    status_seen[4];
    int                    peak_fill;

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(in_item_t item);
      logic [VALUE_IN_W-1:0] v;
      int                    pos;
      logic                  present;
      logic [1:0]            status;
      out_item_t             exp_item;
      v   = item.value & WIDE_MASK[VALUE_IN_W-1:0];
      pos = -1;
      foreach (members[i]) begin
        if (pos < 0 && members[i] == v) pos = i;
      end
      present = (pos >= 0);
      case (item.action)
        ACT_INSERT: begin
          if (present) begin
            status = STAT_DUP;
          end else if (members.size() >= CAPACITY) begin
            status = STAT_FULL;
          end else begin
            members.push_back(v);
            status = STAT_DONE;
          end
        end
        ACT_REMOVE: begin
          if (present) begin
            members.delete(pos);
            status = STAT_DONE;
          end else begin
            status = STAT_ABSENT;
          end
        end
        default: begin
          status = present ? STAT_DONE : STAT_ABSENT;
        end
      endcase
      exp_item.found  = present;
      exp_item.status = status;
      exp_item.count  = COUNT_W'(members.size());
      expected_q.push_back(exp_item);
      status_seen[status]++;
      if (members.size() > peak_fill) peak_fill = members.size();
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      results_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d: no item pending, got found=%0b status=%0d count=%0d",
                         results_checked, got.found, got.status, got.count));
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.found !== exp_item.found || got.status !== exp_item.status ||
          got.count !== exp_item.count) begin
        report($sformatf("result %0d: expected found=%0b status=%0d count=%0d, got found=%0b status=%0d count=%0d",
                         results_checked, exp_item.found, exp_item.status, exp_item.count,
                         got.found, got.status, got.count));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  uvs_scoreboard         sb = new();
  logic [VALUE_IN_W-1:0] value_pool[POOL_SIZE];
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  logic                  hold_req  = 1'b0;
  logic                  hold_done = 1'b0;
  int                    hold_cnt  = 0;
  int                    cycle_count = 0;
  int                    items_sent  = 0;

  unique_value_set_store #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // hold off once for a long stretch, otherwise stall at random
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
    end
  end

  function automatic in_item_t mk(logic [1:0] action, logic [VALUE_IN_W-1:0] value);
    in_item_t item;
    item.action = action;
    item.value  = value;
    return item;
  endfunction

  function automatic in_item_t next_op(int insert_pct);
    int       r;
    in_item_t item;
    r = $urandom_range(99);
    if (r < insert_pct) begin
      item.action = ACT_INSERT;
    end else if (r < insert_pct + (100 - insert_pct) * 3 / 4) begin
      item.action = ACT_REMOVE;
    end else begin
      item.action = ($urandom_range(3) == 0) ? ACT_UNUSED : ACT_QUERY;
    end
    if (item.action != ACT_INSERT && sb.members.size() != 0 && $urandom_range(99) < 70) begin
      item.value = sb.members[$urandom_range(sb.members.size() - 1)];
    end else if ($urandom_range(99) < 60) begin
      item.value = value_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      item.value = $urandom();
    end
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 64, 0, 18};
    recv_pcts = '{0, 0, 64, 18};
    foreach (value_pool[i]) value_pool[i] = $urandom();
    value_pool[0] = '0;
    value_pool[1] = '1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(mk(ACT_QUERY,  32'h0000_0000));
    send_item(mk(ACT_REMOVE, 32'hFFFF_FFFF));
    send_item(mk(ACT_INSERT, 32'h0000_0000));
    send_item(mk(ACT_INSERT, 32'hFFFF_FFFF));
    send_item(mk(ACT_INSERT, 32'h0000_0000));
    send_item(mk(ACT_INSERT, 32'h8000_0000));
    send_item(mk(ACT_INSERT, 32'h0000_0001));
    send_item(mk(ACT_QUERY,  32'hFFFF_FFFF));
    send_item(mk(ACT_QUERY,  32'h7FFF_FFFF));
    send_item(mk(ACT_UNUSED, 32'h0000_0001));
    send_item(mk(ACT_UNUSED, 32'hDEAD_BEEF));
    send_item(mk(ACT_REMOVE, 32'h0000_0000));
    send_item(mk(ACT_REMOVE, 32'h0000_0001));
    send_item(mk(ACT_REMOVE, 32'h1234_5678));
    send_item(mk(ACT_QUERY,  32'h0000_0000));
    send_item(mk(ACT_INSERT, 32'hAAAA_AAAA));
    send_item(mk(ACT_INSERT, 32'h5555_5555));
    send_item(mk(ACT_REMOVE, 32'hFFFF_FFFF));
    send_item(mk(ACT_QUERY,  32'h8000_0000));
    send_item(mk(ACT_REMOVE, 32'h8000_0000));
    send_item(mk(ACT_REMOVE, 32'hAAAA_AAAA));
    send_item(mk(ACT_REMOVE, 32'h5555_5555));
    send_item(mk(ACT_REMOVE, 32'h5555_5555));

    hold_req <= 1'b1;
    repeat (20) send_item(next_op(50));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      recv_stall_pct <= recv_pcts[ph];
      repeat (110) send_item(next_op(80));
      repeat (65) send_item(next_op(10));
    end

    in_valid <= 1'b0;
    recv_stall_pct <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items and checked %0d results: %0d done, %0d duplicate, %0d full, %0d absent.",
             items_sent, sb.results_checked, sb.status_seen[STAT_DONE],
             sb.status_seen[STAT_DUP], sb.status_seen[STAT_FULL], sb.status_seen[STAT_ABSENT]);
    $display("Peak fill %0d of %0d; idle phases none, sender, receiver, both, plus one %0d-cycle output hold.",
             sb.peak_fill, CAPACITY, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
